[sv/sbrp_pkg.sv]
// Shared types, codes and constants for the sorted bus-read patch table.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbrp_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int OP_W   = 3;
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;

  localparam logic [ADDR_W-1:0] HIGH_BASE = 16'h2000;

  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_CHANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] compare;
    logic              use_compare;
    logic              activate;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] bus_data;
  } sbrp_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_data;
    logic [ADDR_W-1:0] out_address;
    logic [BYTE_W-1:0] out_compare;
    logic              out_use_compare;
    logic              hit;
  } sbrp_out_t;

  // stored patch code, active flag kept apart since it alone resets
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] cmp;
    logic              cmp_en;
  } sbrp_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // run the held item, update table, load result
  } sbrp_cmd_t;

endpackage

`default_nettype wire

[sv/sbrp_ctrl.sv]
// Sequencer for the patch table: capture, execute, output handshake.
// Depends on sbrp_pkg.
`default_nettype none

module sbrp_ctrl
  import sbrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sbrp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/sbrp_datapath.sv]
// Item register, sorted row of entry cells and result register.
// Depends on sbrp_pkg; driven by commands from sbrp_ctrl.
`default_nettype none

module sbrp_datapath
  import sbrp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sbrp_cmd_t cmd,
  input  sbrp_in_t  in_item,
  output sbrp_out_t out_item
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  sbrp_in_t    item_r;
  sbrp_out_t   res_r, res_nxt;
  sbrp_entry_t ent_r   [MAX_ENTRIES];
  sbrp_entry_t ent_nxt [MAX_ENTRIES];
  logic        act_r   [MAX_ENTRIES];
  logic        act_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0] count_r, count_nxt;

  // per-cell flags
  logic [MAX_ENTRIES-1:0] valid, lt, match, same, rhit, pass, sel, ge;

  logic item_high, act_hi, full, found, nochange, idx_ok;

  assign item_high = (item_r.address >= HIGH_BASE);
  assign act_hi    = item_r.activate && item_high;
  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  assign found     = |match;
  assign nochange  = |same;
  assign idx_ok    = (16'(item_r.index) < 16'(count_r));

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] CELL_C = CNT_W'(i);
    localparam logic [IDX_W-1:0] CELL_I = IDX_W'(i);

    logic        eq;
    sbrp_entry_t prev_ent, next_ent;
    logic        prev_lt, prev_act, next_act;

    assign eq       = (ent_r[i].addr == item_r.address);
    assign valid[i] = (CELL_C < count_r);
    assign lt[i]    = valid[i] && (ent_r[i].addr < item_r.address);
    assign match[i] = valid[i] && eq;
    assign same[i]  = match[i] && (ent_r[i].value == item_r.data) &&
                      (ent_r[i].cmp == item_r.compare) &&
                      (ent_r[i].cmp_en == item_r.use_compare);
    assign rhit[i]  = act_r[i] && eq && item_high;
    assign pass[i]  = rhit[i] && (!ent_r[i].cmp_en || ent_r[i].cmp == item_r.bus_data);
    assign sel[i]   = valid[i] && (item_r.index == CELL_I);
    assign ge[i]    = (CELL_I >= item_r.index);

    if (i == 0) begin : g_first
      assign prev_ent = ent_r[i];
      assign prev_lt  = 1'b1;     // insertion at the head
      assign prev_act = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent_r[i-1];
      assign prev_lt  = lt[i-1];
      assign prev_act = act_r[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign next_ent = ent_r[i];
      assign next_act = 1'b0;     // tail empties on delete
    end else begin : g_inner
      assign next_ent = ent_r[i+1];
      assign next_act = act_r[i+1];
    end

    always_comb begin
      ent_nxt[i] = ent_r[i];
      act_nxt[i] = act_r[i];
      if (cmd.exec) begin
        unique case (item_r.op)
          OP_SET: begin
            if (found) begin
              if (!nochange && match[i]) begin
                ent_nxt[i].value  = item_r.data;
                ent_nxt[i].cmp    = item_r.compare;
                ent_nxt[i].cmp_en = item_r.use_compare;
                act_nxt[i]        = act_r[i] || act_hi;
              end
            end else if (!full && !lt[i]) begin
              if (prev_lt) begin
                ent_nxt[i].addr   = item_r.address;
                ent_nxt[i].value  = item_r.data;
                ent_nxt[i].cmp    = item_r.compare;
                ent_nxt[i].cmp_en = item_r.use_compare;
                act_nxt[i]        = act_hi;
              end else begin
                ent_nxt[i] = prev_ent;
                act_nxt[i] = prev_act;
              end
            end
          end
          OP_DELETE: begin
            if (idx_ok && ge[i]) begin
              ent_nxt[i] = next_ent;
              act_nxt[i] = next_act;
            end
          end
          OP_CLEAR: act_nxt[i] = 1'b0;
          OP_RESET: begin
            if (valid[i] && ent_r[i].addr >= HIGH_BASE) act_nxt[i] = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // one-hot selections, so plain OR merges them
  logic [BYTE_W-1:0] read_val, get_val, get_cmp;
  logic [ADDR_W-1:0] get_addr;
  logic              get_ce;

  always_comb begin
    read_val = '0;
    get_val  = '0;
    get_cmp  = '0;
    get_addr = '0;
    get_ce   = 1'b0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      read_val = read_val | (pass[k] ? ent_r[k].value : '0);
      get_val  = get_val  | (sel[k] ? ent_r[k].value : '0);
      get_cmp  = get_cmp  | (sel[k] ? ent_r[k].cmp : '0);
      get_addr = get_addr | (sel[k] ? ent_r[k].addr : '0);
      get_ce   = get_ce   | (sel[k] && ent_r[k].cmp_en);
    end
  end

  always_comb begin
    res_nxt   = '0;
    count_nxt = count_r;
    unique case (item_r.op)
      OP_SET: begin
        if (found) begin
          res_nxt.status = nochange ? ST_NO_CHANGE : ST_OK;
        end else if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_OK;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (idx_ok) count_nxt = count_r - CNT_W'(1);
        else        res_nxt.status = ST_BAD_INDEX;
      end
      OP_GET: begin
        if (idx_ok) begin
          res_nxt.out_data        = get_val;
          res_nxt.out_address     = get_addr;
          res_nxt.out_compare     = get_cmp;
          res_nxt.out_use_compare = get_ce;
        end else begin
          res_nxt.status = ST_BAD_INDEX;
        end
      end
      OP_READ: begin
        res_nxt.hit      = |rhit;
        res_nxt.out_data = (|pass) ? read_val : item_r.bus_data;
      end
      OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) res_r <= res_nxt;
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < MAX_ENTRIES; k++) act_r[k] <= 1'b0;
    end else begin
      if (cmd.exec) count_r <= count_nxt;
      act_r <= act_nxt;
    end
  end

  assign out_item = res_r;

endmodule

`default_nettype wire

[sv/sorted_bus_read_patch_table.sv]
// Top level of the sorted bus-read patch table: controller plus datapath.
// Depends on sbrp_pkg, sbrp_ctrl and sbrp_datapath.
//
// The block keeps up to MAX_ENTRIES patch codes in a row of entry
// registers sorted by address, and answers one item at a time: set,
// delete, get, bus read, clear and reset (activate every entry at 0x2000
// or above), each giving exactly one result item. An item is first
// captured in the item register, then evaluated against every entry
// cell in parallel (address compares, insert position, shift), which
// loads the result register. A result not yet taken holds the execute
// step until out_ready takes it. Besides the controller state, only the
// active flags and the entry count are reset; the stored codes are
// covered by the count, so there is no clearing pass and the block
// takes items from the first cycle after reset.
`default_nettype none

module sorted_bus_read_patch_table
  import sbrp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // item channel
  input  logic      in_valid,
  output logic      in_ready,
  input  sbrp_in_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_ready,
  output sbrp_out_t out_item
);

  sbrp_cmd_t cmd;

  // sequencing and both handshakes
  sbrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // table storage, lookup and result register
  sbrp_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the sorted bus-read patch table.
// Depends on sbrp_pkg and sorted_bus_read_patch_table; nothing else.
`default_nettype none

module tb;
  import sbrp_pkg::*;

  // The block takes one item per handshake and answers each with exactly
  // one result item. This bench keeps its own copy of the patch table,
  // predicts every result at the moment the item is accepted, and
  // compares results in order as they leave the block.

  localparam int PATCH_SLOTS    = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int PHASE_ITEMS    = 275;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sbrp_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sbrp_out_t out_item;

  sorted_bus_read_patch_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow patch table and its predictor
  // ---------------------------------------------------------------------
  sbrp_entry_t            tab_entry [PATCH_SLOTS];
  logic [PATCH_SLOTS-1:0] tab_active = '0;
  int                     tab_count = 0;

  sbrp_in_t  item_backlog[$];      // items not yet offered to the block
  sbrp_out_t patch_results_due[$]; // predicted results, oldest first

  int  err_count = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  logic in_taken = 1'b0;           // item accepted at the last rising edge

  // Apply one item to the shadow table and return the result it causes.
  function automatic sbrp_out_t patch_predict(sbrp_in_t it);
    sbrp_out_t r;
    int        pos;
    bit        found;
    r = '0;
    case (it.op)
      OP_SET: begin
        pos = 0;
        while (pos < tab_count && tab_entry[pos].addr < it.address) pos++;
        if (pos < tab_count && tab_entry[pos].addr == it.address) begin
          // same address: identical code leaves even activation alone
          if (tab_entry[pos].value == it.data && tab_entry[pos].cmp == it.compare &&
              tab_entry[pos].cmp_en == it.use_compare)
            r.status = ST_NO_CHANGE;
        end else if (tab_count >= PATCH_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          for (int i = tab_count; i > pos; i--) begin
            tab_entry[i]  = tab_entry[i-1];
            tab_active[i] = tab_active[i-1];
          end
          tab_active[pos] = 1'b0;
          tab_count++;
        end
        if (r.status == ST_OK) begin
          tab_entry[pos] = '{it.address, it.data, it.compare, it.use_compare};
          // low addresses are stored but never go active
          if (it.activate && it.address >= HIGH_BASE) tab_active[pos] = 1'b1;
        end
      end
      OP_DELETE: begin
        if (int'(it.index) < tab_count) begin
          for (int i = int'(it.index); i + 1 < tab_count; i++) begin
            tab_entry[i]  = tab_entry[i+1];
            tab_active[i] = tab_active[i+1];
          end
          tab_count--;
          tab_active[tab_count] = 1'b0;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      OP_GET: begin
        if (int'(it.index) < tab_count) begin
          r.out_data        = tab_entry[it.index].value;
          r.out_address     = tab_entry[it.index].addr;
          r.out_compare     = tab_entry[it.index].cmp;
          r.out_use_compare = tab_entry[it.index].cmp_en;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      OP_READ: begin
        r.out_data = it.bus_data;
        found = 1'b0;
        if (it.address >= HIGH_BASE) begin
          for (int i = 0; i < tab_count; i++) begin
            if (!found && tab_active[i] && tab_entry[i].addr == it.address) begin
              found = 1'b1;
              r.hit = 1'b1;
              // compare mismatch: hit, but the bus byte passes
              if (!tab_entry[i].cmp_en || tab_entry[i].cmp == it.bus_data)
                r.out_data = tab_entry[i].value;
            end
          end
        end
      end
      OP_CLEAR: begin
        tab_active = '0;
        tab_count  = 0;
      end
      OP_RESET: begin
        for (int i = 0; i < tab_count; i++)
          if (tab_entry[i].addr >= HIGH_BASE) tab_active[i] = 1'b1;
      end
      default: ; // spare codes: status ok, all fields zero
    endcase
    return r;
  endfunction

  task automatic note_error(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(sbrp_out_t got);
    sbrp_out_t want;
    if (patch_results_due.size() == 0) begin
      note_error($sformatf("result %h with no item outstanding", got));
      return;
    end
    want = patch_results_due.pop_front();
    if (got.status !== want.status)
      note_error($sformatf("status %h, want %h", got.status, want.status));
    if (got.out_data !== want.out_data)
      note_error($sformatf("out_data %h, want %h", got.out_data, want.out_data));
    if (got.out_address !== want.out_address)
      note_error($sformatf("out_address %h, want %h", got.out_address, want.out_address));
    if (got.out_compare !== want.out_compare)
      note_error($sformatf("out_compare %h, want %h", got.out_compare, want.out_compare));
    if (got.out_use_compare !== want.out_use_compare)
      note_error($sformatf("out_use_compare %b, want %b",
                           got.out_use_compare, want.out_use_compare));
    if (got.hit !== want.hit)
      note_error($sformatf("hit %b, want %b", got.hit, want.hit));
  endtask

  // ---------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) patch_results_due.push_back(patch_predict(in_item));
      if (out_valid && out_ready) check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of items with random gaps, changes at the falling edge.
  // After items 400 and 800 it holds off until every result is back.
  // ---------------------------------------------------------------------
  int items_sent = 0;
  int burst_left = 8;
  int gap_left = 0;
  bit drain_wait = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (drain_wait && patch_results_due.size() == 0) drain_wait = 1'b0;
      if (drain_wait || gap_left != 0 || item_backlog.size() == 0) begin
        in_valid <= 1'b0;
        if (!drain_wait && gap_left != 0) gap_left--;
      end else begin
        in_item  <= item_backlog.pop_front();
        in_valid <= 1'b1;
        items_sent++;
        if (items_sent == 400 || items_sent == 800) drain_wait = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = int'($urandom_range(1, 40));
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
        end
      end
    end
  end

  // Receiver: picks a new stall mode whenever its timer runs out.
  int ready_mode = 0;
  int ready_timer = 0;
  int ready_phase = 0;

  always @(negedge clk) begin
    if (ready_timer == 0) begin
      ready_mode  = int'($urandom_range(0, 3));
      ready_timer = int'($urandom_range(32, 96));
    end
    ready_timer--;
    ready_phase++;
    case (ready_mode)
      0:       out_ready <= 1'b1;                        // never stall
      1:       out_ready <= 1'($urandom_range(0, 1));    // coin toss
      2:       out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
      default: out_ready <= (ready_phase % 5 != 0);      // periodic hiccup
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic sbrp_in_t make_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] cmp,
                                         logic ce, logic act, logic [IDX_W-1:0] idx,
                                         logic [BYTE_W-1:0] bus);
    sbrp_in_t it;
    it.op          = op;
    it.address     = addr;
    it.data        = data;
    it.compare     = cmp;
    it.use_compare = ce;
    it.activate    = act;
    it.index       = idx;
    it.bus_data    = bus;
    return it;
  endfunction

  logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [BYTE_W-1:0] pool_data [POOL_SIZE];
  logic [BYTE_W-1:0] pool_cmp  [POOL_SIZE];
  logic              pool_ce   [POOL_SIZE];

  initial begin
    sbrp_in_t    it;
    logic [63:0] raw;
    int          pick;
    int          k;

    // directed: empty table, boundaries, replace, compare, activation
    item_backlog.push_back(make_item(OP_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'hA5));
    item_backlog.push_back(make_item(OP_READ, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h5A));
    item_backlog.push_back(make_item(OP_GET, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_DELETE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h2000, 8'hFF, 8'h00, 1'b0, 1'b1, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h1FFF, 8'h11, 8'h22, 1'b0, 1'b1, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'hFFFF, 8'h00, 8'hFF, 1'b1, 1'b1, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h0000, 8'h80, 8'h01, 1'b1, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h2000, 8'hFF, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h2000, 8'h3C, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_READ, 16'h2000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h55));
    item_backlog.push_back(make_item(OP_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'hFF));
    item_backlog.push_back(make_item(OP_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h12));
    item_backlog.push_back(make_item(OP_READ, 16'h1FFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h77));
    item_backlog.push_back(make_item(OP_GET, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_GET, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd3, 8'h00));
    item_backlog.push_back(make_item(OP_GET, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd4, 8'h00));
    item_backlog.push_back(make_item(OP_SET, 16'h4000, 8'h99, 8'h66, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_READ, 16'h4000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h01));
    item_backlog.push_back(make_item(OP_RESET, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_READ, 16'h4000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h01));
    item_backlog.push_back(make_item(OP_SPARE6, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF));
    item_backlog.push_back(make_item(OP_SPARE7, 16'h2000, 8'h01, 8'h02, 1'b1, 1'b1, 8'd1, 8'h03));
    item_backlog.push_back(make_item(OP_DELETE, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_CLEAR, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'h00));
    item_backlog.push_back(make_item(OP_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'hFF));

    // random: per phase a small address pool so the table fills up,
    // sets repeat old codes and reads find live entries
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        for (int p = 0; p < POOL_SIZE; p++) begin
          case ($urandom_range(0, 3))
            0:       pool_addr[p] = 16'h1FF8 + 16'($urandom_range(0, 15)); // around 0x2000
            1:       pool_addr[p] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: pool_addr[p] = 16'($urandom);
          endcase
          pool_data[p] = 8'($urandom);
          pool_cmp[p]  = 8'($urandom);
          pool_ce[p]   = 1'($urandom_range(0, 1));
        end
      end
      k    = int'($urandom_range(0, POOL_SIZE - 1));
      pick = int'($urandom_range(0, 99));
      raw  = {$urandom, $urandom};
      it   = raw[$bits(sbrp_in_t)-1:0];
      if (pick < 30) begin
        it.op = OP_SET;
        it.address = pool_addr[k];
        if ($urandom_range(0, 1) != 0) begin
          it.data        = pool_data[k];
          it.compare     = pool_cmp[k];
          it.use_compare = pool_ce[k];
        end
      end else if (pick < 65) begin
        it.op = OP_READ;
        it.address = pool_addr[k];
        if ($urandom_range(0, 1) != 0) it.bus_data = pool_cmp[k];
      end else if (pick < 75) begin
        it.op = OP_GET;
        if ($urandom_range(0, 7) != 0) it.index = IDX_W'($urandom_range(0, PATCH_SLOTS + 1));
      end else if (pick < 83) begin
        it.op = OP_DELETE;
        if ($urandom_range(0, 7) != 0) it.index = IDX_W'($urandom_range(0, PATCH_SLOTS + 1));
      end else if (pick < 88) begin
        it.op = OP_RESET;
      end else if (pick < 89) begin
        it.op = OP_CLEAR;
      end else if (pick < 91) begin
        it.op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
      end
      // the rest: raw noise on every field, op included
      item_backlog.push_back(it);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    fork
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
      end
      begin
        while (item_backlog.size() != 0 || in_valid) @(posedge clk);
        while (patch_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
    join_any
    disable fork;

    if (timed_out) note_error("no handshake for too long");
    if (patch_results_due.size() != 0)
      note_error($sformatf("%0d results never arrived", patch_results_due.size()));
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
